[rtl/assert_macros.svh]
// assertion macros shared by the cache directory rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be true at a clock edge
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/salru_pkg.sv]
// shared types and constants for the lru cache directory
package salru_pkg;

  // parameter defaults
  localparam int MAX_SET_BITS_DEF = 5;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;
  localparam int COUNT_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int STAMP_W     = 32;
  localparam int OUT_COUNT_W = 32;
  localparam int OP_W        = 2;
  localparam int IN_ADDR_W   = 64;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 104;
  localparam int SET_BITS_W  = 3;
  localparam int WAYS_REG_W  = 4;
  localparam int OFFSET_W    = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  // access kinds; the unused code behaves as a load
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS = 2'd0,
    CFG_WAYS     = 2'd1,
    CFG_OFFSET   = 2'd2
  } cfg_idx_t;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // outcome of one set lookup
  typedef struct packed {
    logic hit;
    logic evicted;
  } lookup_t;

endpackage

[rtl/salru_row_mem.sv]
// synchronous set memory, one row per set, registered read
module salru_row_mem import salru_pkg::*; #(
  parameter int ADDR_W = 5,
  parameter int ROW_W  = 776
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/salru_way_sel.sv]
// tag compare, victim choice and updated row for one set
module salru_way_sel import salru_pkg::*; #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64,
  localparam int ENTRY_W   = 1 + ADDR_WIDTH + STAMP_W,
  localparam int ROW_W     = MAX_WAYS * ENTRY_W,
  localparam int WAYS_CNT_W = $clog2(MAX_WAYS + 1),
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [ROW_W-1:0]      row,
  input  logic [ADDR_WIDTH-1:0] tag,
  input  logic [WAYS_CNT_W-1:0] ways,
  input  logic [STAMP_W-1:0]    stamp_new,
  output lookup_t               look,
  output logic [ROW_W-1:0]      row_next
);

  logic                  ent_v     [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] ent_tag   [MAX_WAYS];
  logic [STAMP_W-1:0]    ent_stamp [MAX_WAYS];
  logic [MAX_WAYS-1:0]   in_use;
  logic [MAX_WAYS-1:0]   match;
  logic [MAX_WAYS-1:0]   free;
  logic [MAX_WAYS-1:0]   oldest;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      old_way;
  logic [WAY_W-1:0]      victim;

  // unpack ways and classify them
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      ent_stamp[w] = row[w*ENTRY_W +: STAMP_W];
      ent_tag[w]   = row[w*ENTRY_W + STAMP_W +: ADDR_WIDTH];
      ent_v[w]     = row[w*ENTRY_W + ENTRY_W - 1];
      in_use[w]    = WAYS_CNT_W'(w) < ways;
      match[w]     = in_use[w] && ent_v[w] && (ent_tag[w] == tag);
      free[w]      = in_use[w] && !ent_v[w];
    end
  end

  // pairwise stamp compares: a way is oldest if strictly older than lower
  // ways and no newer than higher ways, which breaks ties toward way zero
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      oldest[w] = in_use[w];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (in_use[j]) begin
          if (j < w) begin
            if (!(ent_stamp[w] < ent_stamp[j])) oldest[w] = 1'b0;
          end else if (j > w) begin
            if (ent_stamp[w] > ent_stamp[j]) oldest[w] = 1'b0;
          end
        end
      end
    end
  end

  // lowest-index pick among matching, free and oldest ways
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w])  hit_way  = WAY_W'(w);
      if (free[w])   free_way = WAY_W'(w);
      if (oldest[w]) old_way  = WAY_W'(w);
    end
  end

  // outcome and the row to write back
  always_comb begin
    look.hit     = |match;
    look.evicted = !(|match) && !(|free);
    if (|match) begin
      victim = hit_way;
    end else if (|free) begin
      victim = free_way;
    end else begin
      victim = old_way;
    end
    row_next = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (victim == WAY_W'(w)) begin
        row_next[w*ENTRY_W +: ENTRY_W] = {1'b1, tag, stamp_new};
      end
    end
  end

endmodule

[rtl/set_assoc_cache_lru_sim_unit.sv]
// top level of the set-associative cache directory with lru replacement
// A request's set row is read from the set memory as it is accepted in ST_IDLE. In ST_LOOKUP
// the tags of the ways in use are compared, a victim is chosen, the row is written back and
// the result register is loaded, once the output register holds no unaccepted result. The
// set memory has one read and one write port, and the row read and the write back of one request
// set the pace. A finished result waits in an output register while the next request is taken.
// After reset a clearing pass writes every row of the set memory, one row a cycle (two rows when
// MAX_SET_BITS is 0); no request is taken meanwhile, configuration writes are and flush nothing.
`include "assert_macros.svh"

module set_assoc_cache_lru_sim_unit import salru_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // operation [1:0], address [65:2], zero [71:66]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // access_hit [0], access_evicted [1], total_hits [33:2], total_misses [65:34],
  // total_evictions [97:66], zero [103:98]
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_AW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ENTRY_W    = 1 + ADDR_WIDTH + STAMP_W;
  localparam int ROW_W      = MAX_WAYS * ENTRY_W;
  localparam int WAYS_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int SHAMT_W    = OFFSET_W + 1;

  state_t                  state, state_next;
  logic [ROW_AW-1:0]       clr_idx;
  logic [SET_BITS_W-1:0]   set_bits;
  logic [WAYS_REG_W-1:0]   ways_in_use;
  logic [OFFSET_W-1:0]     offset_bits;
  logic [SET_BITS_W-1:0]   sb_eff;
  logic [WAYS_CNT_W-1:0]   ways_eff;
  logic [ADDR_WIDTH-1:0]   addr;
  logic [ADDR_WIDTH-1:0]   addr_sh;
  logic [ROW_AW-1:0]       row_mask;
  logic [ROW_AW-1:0]       set_idx;
  logic [SHAMT_W-1:0]      tag_shamt;
  logic [ADDR_WIDTH-1:0]   tag_idx;
  logic [ROW_AW-1:0]       set_q;
  logic [ADDR_WIDTH-1:0]   tag_q;
  logic [OP_W-1:0]         op_q;
  logic                    accept;
  logic                    commit;
  logic                    mem_wr_en;
  logic [ROW_AW-1:0]       mem_wr_addr;
  logic [ROW_W-1:0]        mem_wr_data;
  logic [ROW_W-1:0]        rd_row;
  logic [ROW_W-1:0]        row_next;
  lookup_t                 look;
  logic [STAMP_W-1:0]      access_clock;
  logic [STAMP_W-1:0]      stamp_new;
  logic [COUNT_WIDTH-1:0]  hit_total, hit_total_next;
  logic [COUNT_WIDTH-1:0]  miss_total, miss_total_next;
  logic [COUNT_WIDTH-1:0]  evict_total, evict_total_next;
  logic [COUNT_WIDTH:0]    hit_sum, miss_sum, evict_sum;
  logic [1:0]              hit_inc;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      ways_in_use <= WAYS_REG_W'(1);
      offset_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SET_BITS: set_bits    <= cfg_data[SET_BITS_W-1:0];
        CFG_WAYS:     ways_in_use <= cfg_data[WAYS_REG_W-1:0];
        CFG_OFFSET:   offset_bits <= cfg_data[OFFSET_W-1:0];
        default:      ;
      endcase
    end
  end

  // clamp register values to the built geometry
  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb_eff = SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb_eff = set_bits;
    end
    if (ways_in_use == '0) begin
      ways_eff = WAYS_CNT_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WAYS_CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_CNT_W'(ways_in_use);
    end
  end

  // split the address into set index and tag
  always_comb begin
    addr      = s_tdata[ADDR_WIDTH+1:2];
    addr_sh   = addr >> offset_bits;
    row_mask  = ~({ROW_AW{1'b1}} << sb_eff);
    set_idx   = addr_sh[ROW_AW-1:0] & row_mask;
    tag_shamt = SHAMT_W'(sb_eff) + SHAMT_W'(offset_bits);
    tag_idx   = addr >> tag_shamt;
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + ROW_AW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    commit     = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == {ROW_AW{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        commit = !m_tvalid || m_tready;
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // request fields held for the lookup state
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= set_idx;
      tag_q <= tag_idx;
      op_q  <= s_tdata[OP_W-1:0];
    end
  end

  // set memory write: clearing pass or write back
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = set_q;
    mem_wr_data = row_next;
    if (state == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_idx;
      mem_wr_data = '0;
    end else if (commit) begin
      mem_wr_en = 1'b1;
    end
  end

  salru_row_mem #(
    .ADDR_W (ROW_AW),
    .ROW_W  (ROW_W)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (set_idx),
    .rd_data (rd_row),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign stamp_new = access_clock + STAMP_W'(1);

  salru_way_sel #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_way_sel (
    .row       (rd_row),
    .tag       (tag_q),
    .ways      (ways_eff),
    .stamp_new (stamp_new),
    .look      (look),
    .row_next  (row_next)
  );

  // saturating counter updates
  always_comb begin
    hit_inc   = {1'b0, look.hit} + {1'b0, op_q == OP_MODIFY};
    hit_sum   = {1'b0, hit_total} + (COUNT_WIDTH + 1)'(hit_inc);
    miss_sum  = {1'b0, miss_total} + (COUNT_WIDTH + 1)'(!look.hit);
    evict_sum = {1'b0, evict_total} + (COUNT_WIDTH + 1)'(look.evicted);
    hit_total_next   = hit_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : hit_sum[COUNT_WIDTH-1:0];
    miss_total_next  = miss_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : miss_sum[COUNT_WIDTH-1:0];
    evict_total_next = evict_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                              : evict_sum[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
      hit_total    <= '0;
      miss_total   <= '0;
      evict_total  <= '0;
    end else if (commit) begin
      access_clock <= stamp_new;
      hit_total    <= hit_total_next;
      miss_total   <= miss_total_next;
      evict_total  <= evict_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {(OUT_DATA_W - 2 - 3 * OUT_COUNT_W)'(0),
                  OUT_COUNT_W'(evict_total_next),
                  OUT_COUNT_W'(miss_total_next),
                  OUT_COUNT_W'(hit_total_next),
                  look.evicted, look.hit};
    end
  end

  // checks
  `ASSERT_NEVER(a_hit_evict_excl, clk, rst, commit && look.hit && look.evicted,
                "hit and eviction reported for the same request")
  `ASSERT_NEXT(a_accept_lookup, clk, rst, accept, state == ST_LOOKUP && !s_tready,
               "accepted request did not move to lookup")
  `ASSERT_NEXT(a_miss_only_commit, clk, rst, !commit, $stable(miss_total),
               "miss count moved without a write back")
  `ASSERT_NEVER(a_no_result_clear, clk, rst, state == ST_CLEAR && m_tvalid,
                "result pending during clearing pass")

endmodule

[bench/set_assoc_cache_lru_sim_unit_test.sv]
// self-checking testbench for the lru cache directory: directed and random access streams
module set_assoc_cache_lru_sim_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import salru_pkg::*;

  localparam int LINE_COUNT      = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int PHASE_ITEMS     = 200;
  localparam int RANDOM_PHASES   = 9;
  localparam int PRESSURE_ITEMS  = 60;
  localparam int PRINT_LIMIT     = 40;
  localparam longint TIMEOUT_NS  = 12_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } access_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // operation [1:0], address [65:2], zero [71:66]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // access_hit [0], access_evicted [1], total_hits [33:2], total_misses [65:34],
  // total_evictions [97:66], zero [103:98]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mirror of the directory and its registers
  bit                    dir_valid [LINE_COUNT];
  bit [IN_ADDR_W-1:0]    dir_tag   [LINE_COUNT];
  bit [STAMP_W-1:0]      dir_stamp [LINE_COUNT];
  logic [STAMP_W-1:0]    use_clock = '0;
  logic [31:0]           hit_tally = '0;
  logic [31:0]           miss_tally = '0;
  logic [31:0]           evict_count = '0;
  logic [SET_BITS_W-1:0] reg_set_bits = '0;
  logic [WAYS_REG_W-1:0] reg_ways = 4'd1;
  logic [OFFSET_W-1:0]   reg_offset = '0;

  access_outcome_t pending_outcomes[$];
  access_outcome_t oldest;
  int              mismatch_count = 0;
  int              burst_left = 0;
  bit              hold_off_request = 1'b0;

  set_assoc_cache_lru_sim_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] saturate_inc(input logic [31:0] count);
    return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
  endfunction

  // set index bits after the clamp to the largest set count
  function automatic int active_set_bits();
    return (reg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(reg_set_bits);
  endfunction

  // one access against the mirror directory: lookup, lru fill or eviction, counters
  function automatic access_outcome_t directory_access(input logic [OP_W-1:0] op,
                                                       input logic [IN_ADDR_W-1:0] addr);
    access_outcome_t res;
    int sb, ob, ways, base, way, victim;
    logic [63:0] set_idx, tag;
    logic found;
    sb = active_set_bits();
    ob = int'(reg_offset);
    ways = (reg_ways == 0) ? 1 : ((reg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(reg_ways));
    use_clock = use_clock + 32'd1;
    set_idx = (addr >> ob) & ((64'd1 << sb) - 64'd1);
    tag = (sb + ob >= 64) ? 64'd0 : (addr >> (sb + ob));
    base = int'(set_idx) * MAX_WAYS_DEF;
    found = 1'b0;
    res = '0;
    for (way = 0; way < ways; way++) begin
      if (!found && dir_valid[base+way] && dir_tag[base+way] == tag) begin
        found = 1'b1;
        dir_stamp[base+way] = use_clock;
      end
    end
    res.hit = found;
    if (found) begin
      hit_tally = saturate_inc(hit_tally);
    end else begin
      miss_tally = saturate_inc(miss_tally);
      // first invalid way wins
      victim = ways;
      for (way = ways - 1; way >= 0; way--) begin
        if (!dir_valid[base+way]) victim = way;
      end
      // all valid: oldest stamp, lowest way on ties
      if (victim == ways) begin
        victim = 0;
        for (way = 1; way < ways; way++) begin
          if (dir_stamp[base+way] < dir_stamp[base+victim]) victim = way;
        end
        res.evicted = 1'b1;
        evict_count = saturate_inc(evict_count);
      end
      dir_valid[base+victim] = 1'b1;
      dir_tag[base+victim]   = tag;
      dir_stamp[base+victim] = use_clock;
    end
    // modify stores after its load
    if (op == OP_MODIFY) hit_tally = saturate_inc(hit_tally);
    res.hits      = hit_tally;
    res.misses    = miss_tally;
    res.evictions = evict_count;
    return res;
  endfunction

  // sender gap: mostly short, a few long, with bursts of no gap
  function automatic int next_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      burst_left = $urandom_range(20, 50);
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // address that mostly reuses a few tags and sets so hits and evictions occur
  function automatic logic [IN_ADDR_W-1:0] make_address();
    logic [63:0] tag, set_part, low;
    int sb, ob, pick;
    sb = active_set_bits();
    ob = int'(reg_offset);
    pick = $urandom_range(0, 99);
    if (pick < 20) return {$urandom, $urandom};
    low = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
    tag = (pick < 85) ? 64'($urandom_range(0, 11)) : {$urandom, $urandom};
    set_part = 64'($urandom_range(0, 3)) & ((64'd1 << sb) - 64'd1);
    return (tag << (sb + ob)) | (set_part << ob) | low;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // offer one request; valid stays high on return so a following request can go back to back
  task automatic send_access(input logic [OP_W-1:0] op, input logic [IN_ADDR_W-1:0] addr);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {6'b0, addr, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_outcomes.push_back(directory_access(op, addr));
  endtask

  // stop offering, wait for every outcome, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SET_BITS: reg_set_bits = value[SET_BITS_W-1:0];
      CFG_WAYS:     reg_ways     = value[WAYS_REG_W-1:0];
      CFG_OFFSET:   reg_offset   = value[OFFSET_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // all three registers, unused upper data bits filled with noise
  task automatic configure(input int sb, input int ways, input int ob);
    logic [CFG_DATA_W-1:0] noise;
    logic [SET_BITS_W-1:0] sb_v;
    logic [WAYS_REG_W-1:0] ways_v;
    logic [OFFSET_W-1:0]   ob_v;
    noise  = CFG_DATA_W'($urandom);
    sb_v   = SET_BITS_W'(sb);
    ways_v = WAYS_REG_W'(ways);
    ob_v   = OFFSET_W'(ob);
    write_register(CFG_SET_BITS, {noise[5:3], sb_v});
    write_register(CFG_WAYS, {noise[1:0], ways_v});
    write_register(CFG_OFFSET, ob_v);
  endtask

  // reset configuration: one set, one way; every operation and the all-ones address
  task automatic test_default_config();
    send_access(OP_LOAD, 64'd0);
    send_access(OP_LOAD, 64'd0);
    send_access(OP_STORE, '1);
    send_access(OP_MODIFY, '1);
    send_access(OP_UNUSED, 64'd0);
    wait_idle();
  endtask

  // clamped registers and index plus offset reaching the full address width
  task automatic test_config_extremes();
    configure(7, 15, 63);
    send_access(OP_LOAD, 64'h8000_0000_0000_0000);
    send_access(OP_STORE, 64'h7FFF_FFFF_FFFF_FFFF);
    send_access(OP_MODIFY, 64'h8000_0000_0000_0001);
    wait_idle();
    configure(0, 0, 63);
    send_access(OP_LOAD, 64'h8000_0000_0000_0000);
    send_access(OP_LOAD, 64'h0000_0000_0000_0001);
    wait_idle();
  endtask

  // fill all ways of one set, touch the oldest, then force an lru eviction
  task automatic test_lru_order();
    int n;
    configure(5, 8, 0);
    for (n = 1; n <= MAX_WAYS_DEF; n++) send_access(OP_LOAD, (64'(n) << 5) | 64'd7);
    send_access(OP_STORE, (64'd1 << 5) | 64'd7);
    send_access(OP_LOAD, (64'd9 << 5) | 64'd7);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    int n;
    configure(3, 4, 2);
    hold_off_request = 1'b1;
    burst_left = PRESSURE_ITEMS;
    for (n = 0; n < PRESSURE_ITEMS; n++) begin
      send_access(OP_W'($urandom_range(0, 3)), make_address());
    end
    wait_idle();
  endtask

  // phases of random accesses, each under its own configuration
  task automatic test_random_phases();
    int p, n, ob;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(5, 8, 0);
        1: configure(0, 1, 0);
        2: configure(5, 8, 63);
        default: begin
          ob = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
          configure($urandom_range(0, 7), $urandom_range(0, 15), ob);
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_access(OP_W'($urandom_range(0, 3)), make_address());
      end
      wait_idle();
    end
  endtask

  // receiver ready: stretches of random length, a long hold-off on request
  initial begin : ready_driver
    int span, k, pick;
    logic level;
    bit in_hold;
    @(posedge clk);
    forever begin
      in_hold = 1'b0;
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        in_hold = 1'b1;
        level = 1'b0;
        span = HOLD_OFF_CYCLES;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          level = 1'b1;
          span = $urandom_range(30, 80);
        end else if (pick < 55) begin
          level = 1'b1;
          span = $urandom_range(1, 8);
        end else if (pick < 92) begin
          level = 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          span = $urandom_range(10, 40);
        end
      end
      m_tready <= level;
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_off_request && !in_hold) break;
      end
    end
  end

  // compare each accepted outcome with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("outcome with no access pending");
      end else begin
        oldest = pending_outcomes.pop_front();
        check_field("access_hit", 32'(m_tdata[0]), 32'(oldest.hit));
        check_field("access_evicted", 32'(m_tdata[1]), 32'(oldest.evicted));
        check_field("total_hits", m_tdata[33:2], oldest.hits);
        check_field("total_misses", m_tdata[65:34], oldest.misses);
        check_field("total_evictions", m_tdata[97:66], oldest.evictions);
      end
    end
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_default_config();
    test_config_extremes();
    test_lru_order();
    test_backpressure();
    test_random_phases();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/salru_pkg.sv
rtl/salru_row_mem.sv
rtl/salru_way_sel.sv
rtl/set_assoc_cache_lru_sim_unit.sv
bench/set_assoc_cache_lru_sim_unit_test.sv
